// File: design/mbdrp_pkg.sv
// Shared types, constants and table functions for the M-Bus data record parser.
// Used by mbdrp_parser and mbus_data_record_parser_top; no dependencies.
package mbdrp_pkg;

	localparam logic [7:0] MAX_DIFE       = 8'd10;
	localparam logic [7:0] MAX_VIFE       = 8'd10;
	localparam logic [7:0] VIF_BYTES_KEPT = 8'd8;

	// data kinds taken from the DIF data field
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_INT     = 3'd1;
	localparam logic [2:0] KIND_BCD     = 3'd2;
	localparam logic [2:0] KIND_SKIP    = 3'd3;
	localparam logic [2:0] KIND_VAR     = 3'd4;
	localparam logic [2:0] KIND_SPECIAL = 3'd5;

	// parse status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_CONTROL   = 4'd1;
	localparam logic [3:0] ST_CI        = 4'd2;
	localparam logic [3:0] ST_APP_ERR   = 4'd3;
	localparam logic [3:0] ST_SIGNATURE = 4'd4;
	localparam logic [3:0] ST_DIFE      = 4'd5;
	localparam logic [3:0] ST_VIFE      = 4'd6;
	localparam logic [3:0] ST_SPECIAL   = 4'd7;
	localparam logic [3:0] ST_OVERRUN   = 4'd8;

	typedef struct packed {
		logic        emit;
		logic        kind;
		logic [1:0]  fn;
		logic [40:0] sto;
		logic [19:0] tar;
		logic [9:0]  sub;
		logic [63:0] vif;
		logic [63:0] val;
		logic        pres;
		logic [3:0]  status;
		logic [3:0]  flags;
		logic [7:0]  count;
	} rec_result_t;

	function automatic logic [3:0] dt_len(input logic [3:0] dt);
		logic [3:0] r;
		case (dt)
			4'h1, 4'h9: r = 4'd1;
			4'h2, 4'hA: r = 4'd2;
			4'h3, 4'hB: r = 4'd3;
			4'h4, 4'h5, 4'hC: r = 4'd4;
			4'h6, 4'hE: r = 4'd6;
			4'h7: r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] dt_kind(input logic [3:0] dt);
		logic [2:0] r;
		case (dt)
			4'h1, 4'h2, 4'h3, 4'h4, 4'h6, 4'h7: r = KIND_INT;
			4'h9, 4'hA, 4'hB, 4'hC, 4'hE: r = KIND_BCD;
			4'h5: r = KIND_SKIP;
			4'hD: r = KIND_VAR;
			4'hF: r = KIND_SPECIAL;
			default: r = KIND_NONE;
		endcase
		return r;
	endfunction

	// sign extension of an n-byte integer
	function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] n);
		logic [63:0] r;
		case (n)
			4'd1: r = {{56{v[7]}}, v[7:0]};
			4'd2: r = {{48{v[15]}}, v[15:0]};
			4'd3: r = {{40{v[23]}}, v[23:0]};
			4'd4: r = {{32{v[31]}}, v[31:0]};
			4'd6: r = {{16{v[47]}}, v[47:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// File: design/mbdrp_parser.sv
// Byte-wise telegram parser: header checks, DIF/DIFE/VIF decode, value assembly.
// Depends on mbdrp_pkg.
module mbdrp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            b,
	input  logic                  last,
	output mbdrp_pkg::rec_result_t res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_DIF    = 3'd1;
	localparam logic [2:0] PH_DIFE   = 3'd2;
	localparam logic [2:0] PH_VIF    = 3'd3;
	localparam logic [2:0] PH_VARLEN = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;
	localparam logic [2:0] PH_ERROR  = 3'd7;

	logic [8:0]  pos_q, pos_n, len_q, len_n;
	logic [2:0]  phase_q, phase_n;
	logic [7:0]  fc_q, fc_n, cnt_q, cnt_n;
	logic [40:0] sto_q, sto_n;
	logic [19:0] tar_q, tar_n;
	logic [9:0]  sub_q, sub_n;
	logic [1:0]  fn_q, fn_n;
	logic [3:0]  dt_q, dt_n;
	logic [63:0] vif_q, vif_n;
	logic [63:0] acc_q, acc_n;
	logic [39:0] place_q, place_n;
	logic [2:0]  k_q, k_n;
	logic [3:0]  err_q, err_n, flags_q, flags_n;

	always_comb begin
		logic        do_emit;
		logic [63:0] e_val;
		logic        e_pres;
		logic [7:0]  fc_inc;
		logic [7:0]  fc_dec;
		logic [3:0]  i;
		logic [2:0]  kind;
		logic [7:0]  d;
		logic [63:0] acc_v;
		logic [47:0] prod;
		logic        over;
		logic [3:0]  st;

		pos_n = pos_q; len_n = len_q; phase_n = phase_q; fc_n = fc_q; cnt_n = cnt_q;
		sto_n = sto_q; tar_n = tar_q; sub_n = sub_q; fn_n = fn_q; dt_n = dt_q;
		vif_n = vif_q; acc_n = acc_q; place_n = place_q; k_n = k_q;
		err_n = err_q; flags_n = flags_q;
		do_emit = 1'b0; e_val = '0; e_pres = 1'b0;
		fc_inc = fc_q + 8'd1;
		fc_dec = (fc_q != 8'd0) ? fc_q - 8'd1 : 8'd0;
		i = fc_q[3:0];
		kind = mbdrp_pkg::dt_kind(dt_q);
		d = {4'd0, b[3:0]} + {1'b0, b[7:4], 3'd0} + {3'd0, b[7:4], 1'b0};
		prod = place_q * d;
		acc_v = acc_q;
		over = ({1'b0, pos_q} + 10'd3) > {1'b0, len_q};
		st = mbdrp_pkg::ST_OVERRUN;
		res = '0;
		res.flags = flags_q;
		res.count = cnt_q;

		if (last) begin
			if (err_q != mbdrp_pkg::ST_OK) st = err_q;
			else if (phase_q == PH_DONE) st = mbdrp_pkg::ST_OK;
			else if (phase_q == PH_DIF && over) st = mbdrp_pkg::ST_OK;
			res.emit = 1'b1;
			res.kind = 1'b1;
			res.status = st;
			pos_n = '0; len_n = '0; phase_n = PH_HEADER; fc_n = '0; cnt_n = '0;
			sto_n = '0; tar_n = '0; sub_n = '0; fn_n = '0; dt_n = '0; vif_n = '0;
			acc_n = '0; place_n = 40'd1; k_n = '0; err_n = '0; flags_n = '0;
		end else begin
			pos_n = (pos_q != 9'd511) ? pos_q + 9'd1 : pos_q;
			if (phase_q == PH_HEADER) begin
				if (pos_q == 9'd1) begin
					len_n = {1'b0, b} + 9'd6;
				end else if (pos_q == 9'd4 && b != 8'h08) begin
					err_n = mbdrp_pkg::ST_CONTROL; phase_n = PH_ERROR;
				end else if (pos_q == 9'd6 && b != 8'h72) begin
					err_n = mbdrp_pkg::ST_CI; phase_n = PH_ERROR;
				end else if (pos_q == 9'd16) begin
					if (b[1:0] != 2'b00) begin
						err_n = mbdrp_pkg::ST_APP_ERR; phase_n = PH_ERROR;
					end else begin
						flags_n = flags_q | {1'b0, b[2], b[3], b[4]};
					end
				end else if ((pos_q == 9'd17 || pos_q == 9'd18) && b != 8'h00) begin
					err_n = mbdrp_pkg::ST_SIGNATURE; phase_n = PH_ERROR;
				end
				if (pos_q == 9'd18 && phase_n == PH_HEADER) begin
					if (len_q < 9'd21) begin
						err_n = mbdrp_pkg::ST_OVERRUN; phase_n = PH_ERROR;
					end else begin
						phase_n = PH_DIF;
					end
				end
			end else if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
				if (over) begin
					if (phase_q == PH_DIF) begin
						phase_n = PH_DONE;
					end else begin
						err_n = mbdrp_pkg::ST_OVERRUN; phase_n = PH_ERROR;
					end
				end else begin
					case (phase_q)
						PH_DIF: begin
							if (b == 8'h0F || b == 8'h1F) begin
								if (b == 8'h1F) flags_n = flags_q | 4'b1000;
								phase_n = PH_DONE;
							end else if (b != 8'h2F) begin
								sto_n = {40'd0, b[6]};
								tar_n = '0;
								sub_n = '0;
								fn_n = b[5:4];
								dt_n = b[3:0];
								vif_n = '0;
								fc_n = '0;
								phase_n = b[7] ? PH_DIFE : PH_VIF;
							end
						end
						PH_DIFE: begin
							sto_n = sto_q | (41'(b[3:0]) << ({2'b0, i, 2'b0} + 6'd1));
							tar_n = tar_q | (20'(b[5:4]) << {i, 1'b0});
							sub_n = sub_q | (10'(b[6]) << i);
							fc_n = fc_inc;
							if (b[7]) begin
								if (fc_inc >= mbdrp_pkg::MAX_DIFE) begin
									err_n = mbdrp_pkg::ST_DIFE; phase_n = PH_ERROR;
								end
							end else begin
								fc_n = '0;
								phase_n = PH_VIF;
							end
						end
						PH_VIF: begin
							fc_n = fc_inc;
							if (fc_inc <= mbdrp_pkg::VIF_BYTES_KEPT) vif_n = {vif_q[55:0], b};
							if (b[7]) begin
								if (fc_inc >= mbdrp_pkg::MAX_VIFE) begin
									err_n = mbdrp_pkg::ST_VIFE; phase_n = PH_ERROR;
								end
							end else begin
								acc_n = '0;
								place_n = 40'd1;
								k_n = '0;
								case (kind)
									mbdrp_pkg::KIND_NONE: do_emit = 1'b1;
									mbdrp_pkg::KIND_SPECIAL: begin
										err_n = mbdrp_pkg::ST_SPECIAL; phase_n = PH_ERROR;
									end
									mbdrp_pkg::KIND_VAR: phase_n = PH_VARLEN;
									default: begin
										fc_n = {4'd0, mbdrp_pkg::dt_len(dt_q)};
										phase_n = PH_DATA;
									end
								endcase
							end
						end
						PH_VARLEN: begin
							if (b == 8'd0) begin
								do_emit = 1'b1;
							end else begin
								fc_n = b;
								phase_n = PH_DATA;
							end
						end
						PH_DATA: begin
							if (kind == mbdrp_pkg::KIND_INT) begin
								acc_v = acc_q | (64'(b) << {k_q, 3'b000});
							end else if (kind == mbdrp_pkg::KIND_BCD) begin
								acc_v = acc_q + {16'd0, prod};
								// place * 100 = place * (64 + 32 + 4)
								place_n = (place_q << 6) + (place_q << 5) + (place_q << 2);
							end
							acc_n = acc_v;
							k_n = k_q + 3'd1;
							fc_n = fc_dec;
							if (fc_dec == 8'd0) begin
								do_emit = 1'b1;
								if (kind == mbdrp_pkg::KIND_INT) begin
									e_val = mbdrp_pkg::sext(acc_v, mbdrp_pkg::dt_len(dt_q));
									e_pres = 1'b1;
								end else if (kind == mbdrp_pkg::KIND_BCD) begin
									e_val = acc_v;
									e_pres = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			if (do_emit) begin
				cnt_n = (cnt_q != 8'd255) ? cnt_q + 8'd1 : cnt_q;
				phase_n = PH_DIF;
				res.emit = 1'b1;
				res.kind = 1'b0;
				res.fn = fn_n;
				res.sto = sto_n;
				res.tar = tar_n;
				res.sub = sub_n;
				res.vif = vif_n;
				res.val = e_val;
				res.pres = e_pres;
				res.status = mbdrp_pkg::ST_OK;
				res.count = cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; len_q <= '0; phase_q <= PH_HEADER; fc_q <= '0; cnt_q <= '0;
			sto_q <= '0; tar_q <= '0; sub_q <= '0; fn_q <= '0; dt_q <= '0;
			vif_q <= '0; acc_q <= '0; place_q <= 40'd1; k_q <= '0;
			err_q <= '0; flags_q <= '0;
		end else if (step) begin
			pos_q <= pos_n; len_q <= len_n; phase_q <= phase_n; fc_q <= fc_n; cnt_q <= cnt_n;
			sto_q <= sto_n; tar_q <= tar_n; sub_q <= sub_n; fn_q <= fn_n; dt_q <= dt_n;
			vif_q <= vif_n; acc_q <= acc_n; place_q <= place_n; k_q <= k_n;
			err_q <= err_n; flags_q <= flags_n;
		end
	end

endmodule

// File: design/mbus_data_record_parser_top.sv
// M-Bus variable data record parser top level: input stage, parser, result register.
// Depends on mbdrp_pkg and mbdrp_parser.
//
// Takes an M-Bus long telegram one byte per beat, starting at the 0x68 start
// byte, with end_of_telegram high on the stop byte. Each accepted byte is held
// in an input register, then parsed in a single pass into the result register,
// so a byte can be accepted every cycle unless a held result stalls the input
// register; the rate is one byte per cycle, set only by the result register
// draining. Output: one beat per complete data record (result_kind 0) and one
// status beat (result_kind 1) on the stop byte, after which the parser is back
// in its reset state. BCD values are built with a 40x8 multiply per data byte.
module mbus_data_record_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               end_of_telegram,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [1:0]         function_code,
	output logic [40:0]        storage_number,
	output logic [19:0]        tariff_number,
	output logic [9:0]         subunit_number,
	output logic [63:0]        vif_code,
	output logic signed [63:0] record_value,
	output logic               value_present,
	output logic [3:0]         parse_status,
	output logic [3:0]         meter_flags,
	output logic [7:0]         record_count
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	logic                  fire;
	mbdrp_pkg::rec_result_t res;
	mbdrp_pkg::rec_result_t res_q;

	// parse the held byte once the result register can take a result
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= end_of_telegram;
		end
	end

	mbdrp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.b      (data_s1),
		.last   (last_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = res_q.kind;
	assign function_code  = res_q.fn;
	assign storage_number = res_q.sto;
	assign tariff_number  = res_q.tar;
	assign subunit_number = res_q.sub;
	assign vif_code       = res_q.vif;
	assign record_value   = res_q.val;
	assign value_present  = res_q.pres;
	assign parse_status   = res_q.status;
	assign meter_flags    = res_q.flags;
	assign record_count   = res_q.count;

	a_rec_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_kind |-> parse_status == mbdrp_pkg::ST_OK)
		else $error("data record with nonzero status");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind |-> function_code == 2'd0 && vif_code == 64'd0
			&& value_present == 1'b0 && record_value == 64'sd0)
		else $error("status beat carries record fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(data_s1))
		else $error("input stage lost a stalled byte");

endmodule

// File: test/mbus_data_record_parser_top_tb.sv
// Testbench for mbus_data_record_parser_top: M-Bus long telegrams in, decoded records out.
// Depends on mbdrp_pkg (status codes, data kinds, extension limits) and the design.
// A directed telegram table, then random telegrams, all checked against a local model.
`timescale 1ns / 1ps

module mbus_data_record_parser_top_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int BYTE_TARGET  = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// parser phases of the local model
	typedef enum int {
		PH_HEADER, PH_DIF, PH_DIFE, PH_VIF, PH_VARLEN, PH_DATA, PH_DONE, PH_ERROR
	} phase_e;

	// canned record bodies for the directed telegrams
	typedef enum int {
		BODY_EMPTY, BODY_MIX, BODY_DIFE_MAX, BODY_DIFE_OVF, BODY_VIFE_MAX,
		BODY_VIFE_OVF, BODY_SPECIAL, BODY_MANUF, BODY_MFRAME
	} body_e;

	typedef struct {
		bit        kind;
		bit [1:0]  fn;
		bit [40:0] sto;
		bit [19:0] tar;
		bit [9:0]  sub;
		bit [63:0] vif;
		bit [63:0] val;
		bit        pres;
		bit [3:0]  st;
		bit [3:0]  flg;
		bit [7:0]  cnt;
	} record_t;

	typedef struct {
		bit [7:0] data;
		bit       last;
	} beat_t;

	// one directed telegram: header bytes, body, length skew, early cut, surplus bytes
	// and the final status it must end with
	typedef struct {
		bit [7:0]  ctrl;
		bit [7:0]  ci;
		bit [7:0]  stat;
		bit [15:0] sig;
		body_e     body_id;
		int        l_adj;
		int        cut;
		int        surplus;
		bit [3:0]  final_st;
	} telegram_row_t;

	// byte count and kind per DIF data field
	localparam bit [3:0] FIELD_BYTES [16] = '{0, 1, 2, 3, 4, 4, 6, 8, 0, 1, 2, 3, 4, 0, 6, 0};
	localparam bit [2:0] FIELD_KIND [16] = '{
		mbdrp_pkg::KIND_NONE, mbdrp_pkg::KIND_INT, mbdrp_pkg::KIND_INT, mbdrp_pkg::KIND_INT,
		mbdrp_pkg::KIND_INT, mbdrp_pkg::KIND_SKIP, mbdrp_pkg::KIND_INT, mbdrp_pkg::KIND_INT,
		mbdrp_pkg::KIND_NONE, mbdrp_pkg::KIND_BCD, mbdrp_pkg::KIND_BCD, mbdrp_pkg::KIND_BCD,
		mbdrp_pkg::KIND_BCD, mbdrp_pkg::KIND_VAR, mbdrp_pkg::KIND_BCD, mbdrp_pkg::KIND_SPECIAL
	};

	telegram_row_t telegram_rows [18] = '{
		'{8'h08, 8'h72, 8'h1C, 16'h0000, BODY_MIX,      0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_EMPTY,    0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h53, 8'h72, 8'h00, 16'h0000, BODY_EMPTY,    0, -1, 0, mbdrp_pkg::ST_CONTROL},
		'{8'h08, 8'h78, 8'h00, 16'h0000, BODY_EMPTY,    0, -1, 0, mbdrp_pkg::ST_CI},
		'{8'h08, 8'h72, 8'hFF, 16'h0000, BODY_EMPTY,    0, -1, 0, mbdrp_pkg::ST_APP_ERR},
		'{8'h08, 8'h72, 8'h00, 16'h0100, BODY_EMPTY,    0, -1, 0, mbdrp_pkg::ST_SIGNATURE},
		'{8'h08, 8'h72, 8'h04, 16'h0000, BODY_DIFE_MAX, 0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_DIFE_OVF, 0, -1, 0, mbdrp_pkg::ST_DIFE},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_VIFE_MAX, 0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_VIFE_OVF, 0, -1, 0, mbdrp_pkg::ST_VIFE},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_SPECIAL,  0, -1, 0, mbdrp_pkg::ST_SPECIAL},
		'{8'h08, 8'h72, 8'h10, 16'h0000, BODY_MANUF,    0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h08, 16'h0000, BODY_MFRAME,   0, -1, 0, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_MIX,     -3, -1, 0, mbdrp_pkg::ST_OVERRUN},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_EMPTY,   -1, -1, 0, mbdrp_pkg::ST_OVERRUN},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_MIX,      0, 22, 0, mbdrp_pkg::ST_OVERRUN},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_EMPTY,    0, -1, 4, mbdrp_pkg::ST_OK},
		'{8'h08, 8'h72, 8'h00, 16'h0000, BODY_EMPTY,    0,  5, 0, mbdrp_pkg::ST_OVERRUN}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               end_of_telegram;
	logic               out_valid;
	logic               out_ready;
	logic               result_kind;
	logic [1:0]         function_code;
	logic [40:0]        storage_number;
	logic [19:0]        tariff_number;
	logic [9:0]         subunit_number;
	logic [63:0]        vif_code;
	logic signed [63:0] record_value;
	logic               value_present;
	logic [3:0]         parse_status;
	logic [3:0]         meter_flags;
	logic [7:0]         record_count;

	mbus_data_record_parser_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_telegram(end_of_telegram),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.function_code  (function_code),
		.storage_number (storage_number),
		.tariff_number  (tariff_number),
		.subunit_number (subunit_number),
		.vif_code       (vif_code),
		.record_value   (record_value),
		.value_present  (value_present),
		.parse_status   (parse_status),
		.meter_flags    (meter_flags),
		.record_count   (record_count)
	);

	// stimulus and scoreboard storage
	beat_t    byte_stream[$];
	bit [3:0] final_status_q[$];   // typed-in final status per telegram, order of telegrams
	bit       final_pinned_q[$];   // 1 where the row above carries a typed-in status
	record_t  pending_records[$];
	bit [7:0] body[$];

	int  fail_count;
	int  cycle_count;
	int  bytes_sent;
	int  telegram_count;
	int  data_beats;
	int  status_beats;
	bit  stimulus_done;
	bit  hold_request;

	// local parser state
	int unsigned pos;
	int unsigned tlen;
	phase_e      phase;
	int unsigned fcnt;
	bit [63:0]   sto_acc;
	bit [63:0]   tar_acc;
	bit [63:0]   sub_acc;
	bit [1:0]    fn_r;
	bit [3:0]    dt_r;
	bit [63:0]   vif_acc;
	bit [63:0]   value_acc;
	bit [63:0]   place;
	bit [3:0]    err_code;
	bit [3:0]    flag_acc;
	bit [7:0]    rec_seen;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic clear_parser();
		pos       = 0;
		tlen      = 0;
		phase     = PH_HEADER;
		fcnt      = 0;
		sto_acc   = '0;
		tar_acc   = '0;
		sub_acc   = '0;
		fn_r      = '0;
		dt_r      = '0;
		vif_acc   = '0;
		value_acc = '0;
		place     = 64'd1;
		err_code  = mbdrp_pkg::ST_OK;
		flag_acc  = '0;
		rec_seen  = '0;
	endtask

	task automatic latch_error(input bit [3:0] code);
		err_code = code;
		phase    = PH_ERROR;
	endtask

	task automatic push_record(input bit [63:0] val, input bit pres);
		record_t r;
		if (rec_seen < 8'd255)
			rec_seen++;
		r.kind = 1'b0;
		r.fn   = fn_r;
		r.sto  = sto_acc[40:0];
		r.tar  = tar_acc[19:0];
		r.sub  = sub_acc[9:0];
		r.vif  = vif_acc;
		r.val  = val;
		r.pres = pres;
		r.st   = mbdrp_pkg::ST_OK;
		r.flg  = flag_acc;
		r.cnt  = rec_seen;
		pending_records.insert(pending_records.size(), r);
		phase = PH_DIF;
	endtask

	// value complete: sign-extend INTn, pass BCD through, report no value otherwise
	task automatic close_value();
		bit [63:0] v;
		int nbits;
		v     = value_acc;
		nbits = 8 * FIELD_BYTES[dt_r];
		if (FIELD_KIND[dt_r] == mbdrp_pkg::KIND_INT) begin
			if (nbits < 64 && v[nbits-1])
				v |= ~64'd0 << nbits;
			push_record(v, 1'b1);
		end else if (FIELD_KIND[dt_r] == mbdrp_pkg::KIND_BCD) begin
			push_record(v, 1'b1);
		end else begin
			push_record(64'd0, 1'b0);
		end
	endtask

	task automatic header_step(input int unsigned p, input bit [7:0] b);
		if (p == 1)
			tlen = b + 6;
		else if (p == 4 && b != 8'h08)
			latch_error(mbdrp_pkg::ST_CONTROL);
		else if (p == 6 && b != 8'h72)
			latch_error(mbdrp_pkg::ST_CI);
		else if (p == 16) begin
			// application error bits block the meter flags
			if (b[1:0] != 2'b00)
				latch_error(mbdrp_pkg::ST_APP_ERR);
			else
				flag_acc[2:0] |= {b[2], b[3], b[4]};
		end else if ((p == 17 || p == 18) && b != 8'h00)
			latch_error(mbdrp_pkg::ST_SIGNATURE);
		if (p == 18 && phase == PH_HEADER) begin
			if (tlen < 21)
				latch_error(mbdrp_pkg::ST_OVERRUN);
			else
				phase = PH_DIF;
		end
	endtask

	task automatic record_step(input int unsigned p, input bit [7:0] b);
		int unsigned i;
		// past the payload end: fine between records, an overrun inside one
		if (p + 3 > tlen) begin
			if (phase == PH_DIF)
				phase = PH_DONE;
			else
				latch_error(mbdrp_pkg::ST_OVERRUN);
			return;
		end
		case (phase)
			PH_DIF: begin
				if (b == 8'h0F || b == 8'h1F) begin
					if (b == 8'h1F)
						flag_acc[3] = 1'b1;
					phase = PH_DONE;
				end else if (b != 8'h2F) begin
					sto_acc = {63'd0, b[6]};
					tar_acc = '0;
					sub_acc = '0;
					fn_r    = b[5:4];
					dt_r    = b[3:0];
					vif_acc = '0;
					fcnt    = 0;
					phase   = b[7] ? PH_DIFE : PH_VIF;
				end
			end
			PH_DIFE: begin
				i = fcnt & 15;
				tar_acc |= 64'(b[5:4]) << (2 * i);
				sub_acc |= 64'(b[6]) << i;
				sto_acc |= 64'(b[3:0]) << (4 * i + 1);
				fcnt++;
				if (b[7]) begin
					if (fcnt >= mbdrp_pkg::MAX_DIFE)
						latch_error(mbdrp_pkg::ST_DIFE);
				end else begin
					fcnt  = 0;
					phase = PH_VIF;
				end
			end
			PH_VIF: begin
				fcnt++;
				if (fcnt <= mbdrp_pkg::VIF_BYTES_KEPT)
					vif_acc = {vif_acc[55:0], b};
				if (b[7]) begin
					if (fcnt >= mbdrp_pkg::MAX_VIFE)
						latch_error(mbdrp_pkg::ST_VIFE);
				end else begin
					value_acc = '0;
					place     = 64'd1;
					case (FIELD_KIND[dt_r])
						mbdrp_pkg::KIND_NONE:    push_record(64'd0, 1'b0);
						mbdrp_pkg::KIND_SPECIAL: latch_error(mbdrp_pkg::ST_SPECIAL);
						mbdrp_pkg::KIND_VAR:     phase = PH_VARLEN;
						default: begin
							fcnt  = FIELD_BYTES[dt_r];
							phase = PH_DATA;
						end
					endcase
				end
			end
			PH_VARLEN: begin
				if (b == 8'h00)
					push_record(64'd0, 1'b0);
				else begin
					fcnt  = b;
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (FIELD_KIND[dt_r] == mbdrp_pkg::KIND_INT) begin
					value_acc += place * 64'(b);
					place = place << 8;
				end else if (FIELD_KIND[dt_r] == mbdrp_pkg::KIND_BCD) begin
					value_acc += place * 64'(b[3:0] + 10 * b[7:4]);
					place = place * 64'd100;
				end
				if (fcnt > 0)
					fcnt--;
				if (fcnt == 0)
					close_value();
			end
			default: ;
		endcase
	endtask

	// one accepted beat into the local parser
	task automatic parse_beat(input bit [7:0] b, input bit last);
		record_t r;
		int unsigned p;
		p = pos;
		if (last) begin
			r      = '{default: '0};
			r.kind = 1'b1;
			if (err_code != mbdrp_pkg::ST_OK)
				r.st = err_code;
			else if (phase == PH_DONE || (phase == PH_DIF && p + 3 > tlen))
				r.st = mbdrp_pkg::ST_OK;
			else
				r.st = mbdrp_pkg::ST_OVERRUN;
			r.flg = flag_acc;
			r.cnt = rec_seen;
			pending_records.insert(pending_records.size(), r);
			clear_parser();
			return;
		end
		if (phase == PH_HEADER)
			header_step(p, b);
		else if (phase >= PH_DIF && phase <= PH_DATA)
			record_step(p, b);
		pos = (p < 511) ? p + 1 : 511;
	endtask

	task automatic check_field(input string name, input bit [63:0] want, input bit [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Telegram building
	// ---------------------------------------------------------------------

	task automatic add_bytes(input bit [7:0] b, input int n);
		repeat (n) body.insert(body.size(), b);
	endtask

	task automatic load_body(input body_e id);
		body.delete();
		case (id)
			BODY_MIX: begin
				// filler, int8 negative, int16, int64 all ones, BCD 8, var length,
				// real skipped, no data, selection, empty var, int32 with storage bit,
				// BCD 12 with non-decimal nibbles last
				body = {8'h2F, 8'h01, 8'h13, 8'hFD, 8'h02, 8'h13, 8'h34, 8'h12, 8'h07, 8'h13};
				add_bytes(8'hFF, 8);
				body = {body, 8'h0C, 8'h13, 8'h99, 8'h99, 8'h99, 8'h99};
				body = {body, 8'h0D, 8'h13, 8'h03, 8'hAA, 8'hBB, 8'hCC};
				body = {body, 8'h05, 8'h13, 8'h00, 8'h00, 8'h80, 8'h3F};
				body = {body, 8'h00, 8'h13, 8'h08, 8'h13, 8'h0D, 8'hFD, 8'h00, 8'h00};
				body = {body, 8'h44, 8'h13, 8'h00, 8'h00, 8'h00, 8'h80, 8'h0E, 8'h13};
				add_bytes(8'hFF, 6);
			end
			BODY_DIFE_MAX: begin
				// ten DIFEs, every storage, tariff and subunit bit set
				body = {8'hC4};
				add_bytes(8'hFF, 9);
				body = {body, 8'h7F, 8'h13, 8'h01, 8'h02, 8'h03, 8'h04};
			end
			BODY_DIFE_OVF: begin
				body = {8'h84};
				add_bytes(8'hFF, 10);
				body = {body, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00};
			end
			BODY_VIFE_MAX: begin
				// ten VIF bytes, only eight kept
				body = {8'h01};
				add_bytes(8'hFF, 9);
				body = {body, 8'h7F, 8'h55};
			end
			BODY_VIFE_OVF: begin
				body = {8'h01};
				add_bytes(8'hFF, 10);
				body = {body, 8'h00, 8'h00};
			end
			BODY_SPECIAL: body = {8'h3F, 8'h13, 8'h01, 8'h02};
			BODY_MANUF:   body = {8'h01, 8'h13, 8'h05, 8'h0F, 8'h12, 8'h34, 8'h56};
			BODY_MFRAME:  body = {8'h02, 8'h13, 8'h00, 8'hFF, 8'h1F};
			default: ;
		endcase
	endtask

	// frame the current body and queue its beats; cut >= 0 sends only that many
	// bytes before the stop beat
	task automatic queue_telegram(input bit [7:0] ctrl, input bit [7:0] ci, input bit [7:0] stat,
			input bit [15:0] sig, input int l_adj, input int cut, input int surplus,
			input bit pinned, input bit [3:0] final_st);
		bit [7:0] frame[$];
		int len;
		beat_t bt;
		len = 15 + body.size() + l_adj;
		if (len < 0)
			len = 0;
		if (len > 255)
			len = 255;
		frame = {8'h68, 8'(len), 8'(len), 8'h68, ctrl, 8'($urandom), ci};
		// id, manufacturer, version, medium, access number
		repeat (9) frame.insert(frame.size(), 8'($urandom));
		frame = {frame, stat, sig[15:8], sig[7:0]};
		frame = {frame, body};
		frame.insert(frame.size(), 8'($urandom));
		repeat (surplus) frame.insert(frame.size(), 8'($urandom));
		if (cut >= 0 && cut < frame.size())
			frame = frame[0:cut-1];
		foreach (frame[k]) begin
			bt.data = frame[k];
			bt.last = 1'b0;
			byte_stream.insert(byte_stream.size(), bt);
		end
		bt.data = 8'h16;
		bt.last = 1'b1;
		byte_stream.insert(byte_stream.size(), bt);
		final_status_q.insert(final_status_q.size(), final_st);
		final_pinned_q.insert(final_pinned_q.size(), pinned);
		telegram_count++;
	endtask

	// one random record, mostly well formed, now and then over the extension limits
	task automatic add_random_record();
		bit [3:0] dt;
		int n_dife, n_vif, n_data, sel;
		bit [7:0] b;
		if ($urandom_range(0, 99) < 5)
			body.insert(body.size(), 8'h2F);
		dt = $urandom_range(0, 99) < 3 ? 4'hF : 4'($urandom_range(0, 14));
		sel = $urandom_range(0, 99);
		n_dife = sel < 70 ? 0 : sel < 96 ? $urandom_range(1, 3) : $urandom_range(9, 10);
		b = {n_dife > 0, 1'($urandom), 2'($urandom), dt};
		body.insert(body.size(), b);
		for (int k = 0; k < n_dife; k++)
			body.insert(body.size(), {(k < n_dife - 1) || (n_dife == 10), 7'($urandom)});
		sel = $urandom_range(0, 99);
		n_vif = sel < 97 ? $urandom_range(1, 3) : $urandom_range(8, 11);
		for (int k = 0; k < n_vif; k++)
			body.insert(body.size(), {k < n_vif - 1, 7'($urandom)});
		if (FIELD_KIND[dt] == mbdrp_pkg::KIND_VAR) begin
			sel = $urandom_range(0, 99);
			n_data = sel < 20 ? 0 : sel < 98 ? $urandom_range(1, 6) : $urandom_range(0, 255);
			body.insert(body.size(), 8'(n_data));
		end else begin
			n_data = FIELD_BYTES[dt];
		end
		repeat (n_data) body.insert(body.size(), 8'($urandom));
	endtask

	task automatic queue_random_telegram();
		bit [7:0] ctrl, ci, stat;
		bit [15:0] sig;
		int l_adj, cut, surplus, n;
		ctrl = $urandom_range(0, 99) < 95 ? 8'h08 : 8'($urandom);
		ci   = $urandom_range(0, 99) < 95 ? 8'h72 : 8'($urandom);
		stat = 8'($urandom);
		if ($urandom_range(0, 99) < 85)
			stat[1:0] = 2'b00;
		sig = $urandom_range(0, 99) < 95 ? 16'h0000 : 16'($urandom);
		body.delete();
		if ($urandom_range(0, 99) < 8) begin
			// noise body
			repeat ($urandom_range(0, 30)) body.insert(body.size(), 8'($urandom));
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) add_random_record();
			case ($urandom_range(0, 19))
				0: body = {body, 8'h0F, 8'($urandom), 8'($urandom)};
				1: body.insert(body.size(), 8'h1F);
				default: ;
			endcase
		end
		if (body.size() > 230)
			body = body[0:229];
		l_adj   = $urandom_range(0, 99) < 8 ? $urandom_range(0, 8) - 4 : 0;
		surplus = $urandom_range(0, 99) < 8 ? $urandom_range(1, 4) : 0;
		cut     = $urandom_range(0, 99) < 6 ? $urandom_range(0, body.size() + 20) : -1;
		queue_telegram(ctrl, ci, stat, sig, l_adj, cut, surplus, 1'b0, mbdrp_pkg::ST_OK);
	endtask

	// ---------------------------------------------------------------------
	// Sender: one beat at a time, random gaps, some telegrams gap-free
	// ---------------------------------------------------------------------
	initial begin
		beat_t bt;
		int gap;
		bit calm;
		fail_count     = 0;
		bytes_sent     = 0;
		telegram_count = 0;
		stimulus_done  = 1'b0;
		hold_request   = 1'b0;
		in_valid        <= 1'b0;
		data_byte       <= 8'h00;
		end_of_telegram <= 1'b0;
		arst_n          <= 1'b0;
		clear_parser();

		// directed table first, random telegrams until the byte budget is spent
		foreach (telegram_rows[r]) begin
			load_body(telegram_rows[r].body_id);
			queue_telegram(telegram_rows[r].ctrl, telegram_rows[r].ci, telegram_rows[r].stat,
				telegram_rows[r].sig, telegram_rows[r].l_adj, telegram_rows[r].cut,
				telegram_rows[r].surplus, 1'b1, telegram_rows[r].final_st);
		end
		while (byte_stream.size() < BYTE_TARGET + 50)
			queue_random_telegram();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b0;
		while (byte_stream.size() > 0) begin
			bt = byte_stream.pop_front();
			gap = calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid        <= 1'b1;
			data_byte       <= bt.data;
			end_of_telegram <= bt.last;
			do
				@(posedge clk);
			while (!(in_valid && in_ready));
			bytes_sent++;
			if (bytes_sent == 400)
				hold_request = 1'b1;
			if (bt.last)
				calm = ($urandom_range(0, 3) == 0);
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// ---------------------------------------------------------------------
	// Receiver: random stalls per beat, calm stretches, one long hold-off
	// while the sender keeps offering so the parser backs up
	// ---------------------------------------------------------------------
	initial begin
		int stall;
		int calm_left;
		out_ready <= 1'b0;
		calm_left = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else if (calm_left > 0) begin
				calm_left--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 8);
				if ($urandom_range(0, 29) == 0)
					calm_left = 30;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready));
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: model every accepted input beat, check every result beat
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		record_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_beat(data_byte, end_of_telegram);
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					$error("result beat with nothing expected (kind %0d, status %0d)",
						result_kind, parse_status);
					fail_count++;
				end else begin
					e = pending_records.pop_front();
					check_field("result_kind", e.kind, result_kind);
					check_field("function_code", e.fn, function_code);
					check_field("storage_number", e.sto, storage_number);
					check_field("tariff_number", e.tar, tariff_number);
					check_field("subunit_number", e.sub, subunit_number);
					check_field("vif_code", e.vif, vif_code);
					check_field("record_value", e.val, record_value);
					check_field("value_present", e.pres, value_present);
					check_field("parse_status", e.st, parse_status);
					check_field("meter_flags", e.flg, meter_flags);
					check_field("record_count", e.cnt, record_count);
					if (e.kind) begin
						status_beats++;
						// directed rows also carry a hand-written final status
						if (final_pinned_q.size() > 0) begin
							if (final_pinned_q.pop_front())
								check_field("parse_status (table)",
									final_status_q[0], parse_status);
							final_status_q.pop_front();
						end
					end else begin
						data_beats++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_records.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// end of run
	initial begin
		cycle_count  = 0;
		data_beats   = 0;
		status_beats = 0;
		wait (stimulus_done);
		while (pending_records.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		foreach (pending_records[k]) begin
			$error("result never arrived (kind %0d, status %0d)",
				pending_records[k].kind, pending_records[k].st);
			fail_count++;
		end
		$display("%0d telegrams, %0d bytes: %0d data records and %0d status beats compared",
			telegram_count, bytes_sent, data_beats, status_beats);
		$display("covered header errors, extension limits, fillers, overruns and early ends");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
